@@ rtl/dls_pkg.sv @@
// dls_pkg: shared types, constants and helpers of the distance lod selector
// used by dls_flow, distance_lod_selector_core and the checker
package dls_pkg;

    localparam int LOD_LEVELS  = 5;
    localparam int LOD_W       = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    // pipeline stage map
    localparam int NST         = 45;
    localparam int ST_SQ_FIRST = 4;
    localparam int SQ_BITS     = 35;
    localparam int ST_SQ_LAST  = ST_SQ_FIRST + SQ_BITS - 1;
    localparam int DIV_BITS    = 42;
    localparam int ST_EXT      = ST_SQ_LAST + 1;
    localparam int ST_LHS      = ST_EXT + 1;
    localparam int ST_LEVEL    = ST_LHS + 1;
    localparam int ST_BAND     = DIV_BITS + 1;
    localparam int ST_OUT      = NST - 1;

    localparam logic [31:0] ONE_Q16  = 32'd65536;
    localparam logic [15:0] BIAS_MIN = 16'd64;
    localparam logic [9:0]  HYST     = 10'd35;
    localparam logic [9:0]  THR [4]  = '{10'd115, 10'd225, 10'd450, 10'd800};
    localparam logic [LOD_W-1:0] LOD_TOP = LOD_W'(LOD_LEVELS - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOD_BIAS   = 3'd0,
        CFG_MAX_LOD    = 3'd1,
        CFG_WORLD_X    = 3'd2,
        CFG_HMAP_WIDTH = 3'd3,
        CFG_CAMERA_X   = 3'd4,
        CFG_CAMERA_Y   = 3'd5,
        CFG_CAMERA_Z   = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic                mode;
        logic                pass;
        logic [LOD_W-1:0]    cur;
        logic [2:0][33:0]    dd;
        logic [2:0][33:0]    pl;
        logic [2:0][33:0]    pm;
        logic [2:0][33:0]    ph;
        logic [2:0][67:0]    sq;
        logic [67:0]         rem;
        logic [34:0]         root;
        logic signed [33:0]  es;
        logic [32:0]         ext;
        logic [33:0]         dp0;
        logic [32:0]         dp1;
        logic [59:0]         lhs;
        logic [3:0][51:0]    thx;
        logic [LOD_W-1:0]    lod;
        logic [15:0]         drem;
        logic [41:0]         dnum;
        logic [61:0]         blo;
        logic [61:0]         bhi;
        logic [LOD_W-1:0]    new_lod;
        logic                mesh;
        logic                gpu;
    } stage_t;

    typedef struct packed {
        logic [NST-1:0] ld;
        logic [NST-1:0] vld;
    } flow_t;

    function automatic logic [33:0] abs_delta(input logic [31:0] cam,
                                              input logic [31:0] lo,
                                              input logic [31:0] hi);
        logic signed [34:0] t;
        t = 35'(signed'(cam)) + 35'(signed'(cam)) - 35'(signed'(lo)) - 35'(signed'(hi));
        return t[34] ? 34'(-t) : t[33:0];
    endfunction

endpackage

@@ rtl/dls_flow.sv @@
// dls_flow: valid bits and per-stage load enables of the selector pipeline
// depends on dls_pkg
module dls_flow
    import dls_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    output flow_t flow
);

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST-1:0] ld;

    // a stage loads when empty or when its content moves on
    always_comb
    begin
        ld[NST-1] = !vld_reg[NST-1] || out_ready;
        for (int k = NST - 2; k >= 0; k--)
        begin
            ld[k] = !vld_reg[k] || ld[k+1];
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (ld[0])
        begin
            vld_next[0] = in_valid;
        end
        for (int k = 1; k < NST; k++)
        begin
            if (ld[k])
            begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready  = ld[0];
    assign out_valid = vld_reg[NST-1];
    assign flow.ld   = ld;
    assign flow.vld  = vld_reg;

endmodule

@@ rtl/distance_lod_selector_core.sv @@
// Distance based level of detail selector with hysteresis, one chunk per request.
// 45-stage pipeline: an item enters every cycle while in_ready is high; the length is
// set by the one-bit-per-stage square root (35 stages) and the 42-stage quotient of
// the hysteresis extent. A stall at the output holds only the stages that are full;
// bubbles close up. The user writes configuration through the plain write port only
// while no request is in flight, unenforced. Depends on dls_pkg and dls_flow.
module distance_lod_selector_core
    import dls_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  mode,
    input  logic                  visible,
    input  logic signed [31:0]    box_min_x,
    input  logic signed [31:0]    box_min_y,
    input  logic signed [31:0]    box_min_z,
    input  logic signed [31:0]    box_max_x,
    input  logic signed [31:0]    box_max_y,
    input  logic signed [31:0]    box_max_z,
    input  logic [LOD_W-1:0]      current_lod,
    input  logic [9:0]            chunk_quads,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [LOD_W-1:0]      new_lod,
    output logic                  mesh_dirty,
    output logic                  gpu_dirty
);

    logic [15:0]        lod_bias_reg;
    logic [LOD_W-1:0]   max_lod_reg;
    logic [31:0]        world_x_reg;
    logic [15:0]        hmap_width_reg;
    logic signed [31:0] camera_x_reg;
    logic signed [31:0] camera_y_reg;
    logic signed [31:0] camera_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lod_bias_reg   <= 16'd256;
            max_lod_reg    <= 3'd4;
            world_x_reg    <= 32'd67108864;
            hmap_width_reg <= 16'd1025;
            camera_x_reg   <= '0;
            camera_y_reg   <= '0;
            camera_z_reg   <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_LOD_BIAS:   lod_bias_reg   <= cfg_data[15:0];
                CFG_MAX_LOD:    max_lod_reg    <= cfg_data[LOD_W-1:0];
                CFG_WORLD_X:    world_x_reg    <= cfg_data;
                CFG_HMAP_WIDTH: hmap_width_reg <= cfg_data[15:0];
                CFG_CAMERA_X:   camera_x_reg   <= cfg_data;
                CFG_CAMERA_Y:   camera_y_reg   <= cfg_data;
                CFG_CAMERA_Z:   camera_z_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    // derived configuration, to be kept static by the user while requests are in flight (not enforced)
    logic [15:0]      hw_div;
    logic [15:0]      bias_c;
    logic [LOD_W-1:0] lod_cap;
    logic [31:0]      small_ext;

    assign hw_div    = (hmap_width_reg > 16'd1) ? hmap_width_reg - 16'd1 : 16'd1;
    assign bias_c    = (lod_bias_reg < BIAS_MIN) ? BIAS_MIN : lod_bias_reg;
    assign lod_cap   = (max_lod_reg > LOD_TOP) ? LOD_TOP : max_lod_reg;
    assign small_ext = (hmap_width_reg > 16'd1) ? (world_x_reg >> 3) : world_x_reg;

    flow_t flow;

    dls_flow u_flow (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .flow      (flow)
    );

    stage_t st_reg  [NST];
    stage_t st_next [NST];

    // entry stage: deltas, extent, hysteresis dividend
    always_comb
    begin
        logic [9:0]         q;
        logic signed [33:0] ex;
        logic signed [33:0] ez;
        st_next[0]      = st_reg[0];
        q               = (chunk_quads == 10'd0) ? 10'd1 : chunk_quads;
        ex              = 34'(box_max_x) - 34'(box_min_x);
        ez              = 34'(box_max_z) - 34'(box_min_z);
        st_next[0].mode = mode;
        st_next[0].cur  = current_lod;
        st_next[0].pass = (box_min_x <= box_max_x) && (mode || visible);
        st_next[0].dd[0] = abs_delta(camera_x_reg, box_min_x, box_max_x);
        st_next[0].dd[1] = abs_delta(camera_y_reg, box_min_y, box_max_y);
        st_next[0].dd[2] = abs_delta(camera_z_reg, box_min_z, box_max_z);
        st_next[0].es   = (ex > ez) ? ex : ez;
        st_next[0].dnum = 42'(world_x_reg) * 42'(q);
        st_next[0].drem = '0;
    end

    for (genvar k = 1; k < NST; k++)
    begin : g_stage
        localparam int SB = (k >= ST_SQ_FIRST && k <= ST_SQ_LAST) ? ST_SQ_LAST - k : 0;

        always_comb
        begin
            logic [16:0]    dt;
            logic [71:0]    trial;
            logic [42:0]    e2;
            logic [50:0]    e2s;
            logic [1:0]     band;
            logic [LOD_W:0] lod_w;
            logic [LOD_W:0] cur_w;
            logic           refine;
            logic           coarsen;
            logic           in_band;
            st_next[k] = st_reg[k-1];
            dt      = '0;
            trial   = '0;
            e2      = '0;
            e2s     = '0;
            band    = '0;
            lod_w   = '0;
            cur_w   = '0;
            refine  = 1'b0;
            coarsen = 1'b0;
            in_band = 1'b0;

            // restoring division, one quotient bit per stage
            if (k <= DIV_BITS)
            begin
                dt = {st_reg[k-1].drem, st_reg[k-1].dnum[41]};
                if (dt >= {1'b0, hw_div})
                begin
                    st_next[k].drem = 16'(dt - {1'b0, hw_div});
                    st_next[k].dnum = {st_reg[k-1].dnum[40:0], 1'b1};
                end
                else
                begin
                    st_next[k].drem = dt[15:0];
                    st_next[k].dnum = {st_reg[k-1].dnum[40:0], 1'b0};
                end
            end

            if (k == 1)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    st_next[k].pl[a] = 34'(st_reg[k-1].dd[a][16:0]) * 34'(st_reg[k-1].dd[a][16:0]);
                    st_next[k].pm[a] = 34'(st_reg[k-1].dd[a][16:0]) * 34'(st_reg[k-1].dd[a][33:17]);
                    st_next[k].ph[a] = 34'(st_reg[k-1].dd[a][33:17]) * 34'(st_reg[k-1].dd[a][33:17]);
                end
            end

            if (k == 2)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    st_next[k].sq[a] = (68'(st_reg[k-1].ph[a]) << 34)
                                     + (68'(st_reg[k-1].pm[a]) << 18)
                                     + 68'(st_reg[k-1].pl[a]);
                end
            end

            if (k == 3)
            begin
                st_next[k].rem  = st_reg[k-1].sq[0] + st_reg[k-1].sq[1] + st_reg[k-1].sq[2];
                st_next[k].root = '0;
            end

            // square root, one result bit per stage
            if (k >= ST_SQ_FIRST && k <= ST_SQ_LAST)
            begin
                trial = (72'(st_reg[k-1].root) << (SB + 1)) | (72'd1 << (2 * SB));
                if (trial <= 72'(st_reg[k-1].rem))
                begin
                    st_next[k].rem      = 68'(72'(st_reg[k-1].rem) - trial);
                    st_next[k].root[SB] = 1'b1;
                end
            end

            if (k == ST_EXT)
            begin
                if (st_reg[k-1].es < 34'sd65536)
                begin
                    st_next[k].ext = (small_ext < ONE_Q16) ? 33'(ONE_Q16) : 33'(small_ext);
                end
                else
                begin
                    st_next[k].ext = st_reg[k-1].es[32:0];
                end
                st_next[k].dp0 = 34'(st_reg[k-1].root[17:0]) * 34'(bias_c);
                st_next[k].dp1 = 33'(st_reg[k-1].root[34:18]) * 33'(bias_c);
            end

            if (k == ST_LHS)
            begin
                st_next[k].lhs = ((60'(st_reg[k-1].dp1) << 18) + 60'(st_reg[k-1].dp0)) * 60'd100;
                for (int t = 0; t < 4; t++)
                begin
                    st_next[k].thx[t] = (52'(st_reg[k-1].ext) * 52'(THR[t])) << 9;
                end
            end

            if (k == ST_LEVEL)
            begin
                st_next[k].lod = '0;
                for (int t = 0; t < 4; t++)
                begin
                    if (st_reg[k-1].lhs > 60'(st_reg[k-1].thx[t]))
                    begin
                        st_next[k].lod = LOD_W'(t + 1);
                    end
                end
                if (st_next[k].lod > lod_cap)
                begin
                    st_next[k].lod = lod_cap;
                end
            end

            if (k == ST_BAND)
            begin
                e2   = (st_reg[k-1].dnum < 42'(ONE_Q16)) ? 43'(ONE_Q16) : 43'(st_reg[k-1].dnum);
                e2s  = 51'(e2) << 9;
                band = (st_reg[k-1].lod >= 3'd4) ? 2'd3 :
                       (st_reg[k-1].lod >= 3'd1) ? 2'(st_reg[k-1].lod - 3'd1) : 2'd0;
                st_next[k].blo = 62'(e2s) * 62'(THR[band] - HYST);
                st_next[k].bhi = 62'(e2s) * 62'(THR[band] + HYST);
            end

            if (k == ST_OUT)
            begin
                lod_w   = {1'b0, st_reg[k-1].lod};
                cur_w   = {1'b0, st_reg[k-1].cur};
                refine  = lod_w < cur_w;
                coarsen = lod_w > cur_w + 4'd1;
                in_band = (st_reg[k-1].blo < 62'(st_reg[k-1].lhs))
                       && (62'(st_reg[k-1].lhs) < st_reg[k-1].bhi);
                st_next[k].new_lod = st_reg[k-1].cur;
                st_next[k].mesh    = 1'b0;
                st_next[k].gpu     = 1'b0;
                if (st_reg[k-1].pass && (st_reg[k-1].lod != st_reg[k-1].cur))
                begin
                    if (st_reg[k-1].mode)
                    begin
                        st_next[k].new_lod = st_reg[k-1].lod;
                        st_next[k].mesh    = 1'b1;
                        st_next[k].gpu     = 1'b1;
                    end
                    else if (refine || (coarsen && !in_band))
                    begin
                        st_next[k].new_lod = st_reg[k-1].lod;
                        st_next[k].mesh    = 1'b1;
                    end
                end
            end
        end
    end

    // payload registers, no reset
    for (genvar k = 0; k < NST; k++)
    begin : g_preg
        always_ff @(posedge clk)
        begin
            if (flow.ld[k])
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign new_lod    = st_reg[ST_OUT].new_lod;
    assign mesh_dirty = st_reg[ST_OUT].mesh;
    assign gpu_dirty  = st_reg[ST_OUT].gpu;

endmodule

@@ rtl/dls_checker.sv @@
// dls_checker: port-level assertions on distance_lod_selector_core, bound to it below
// depends on dls_pkg
module dls_checker
    import dls_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [LOD_W-1:0]      new_lod,
    input logic                  mesh_dirty,
    input logic                  gpu_dirty
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(new_lod)
            && $stable(mesh_dirty) && $stable(gpu_dirty))
        else $error("result changed while stalled");

    // a seed change is always a mesh change
    a_gpu_mesh: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && gpu_dirty |-> mesh_dirty)
        else $error("gpu dirty without mesh dirty");

    // an applied level never exceeds the top level
    a_lod_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mesh_dirty |-> new_lod <= LOD_TOP)
        else $error("applied level out of range");

    // pipeline empty out of reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result present right after reset");

endmodule

bind distance_lod_selector_core dls_checker u_dls_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .new_lod    (new_lod),
    .mesh_dirty (mesh_dirty),
    .gpu_dirty  (gpu_dirty)
);

@@ tb/distance_lod_selector_core_tb.sv @@
// testbench of distance_lod_selector_core: directed and random chunk requests,
// expected levels computed by a local selector model and checked field by field
// depends on dls_pkg and the distance_lod_selector_core rtl
module distance_lod_selector_core_tb
    import dls_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic MODE_UPDATE = 1'b0;
    localparam logic MODE_SEED   = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int PHASES = 9;
    localparam int ITEMS_PER_PHASE = 170;

    typedef struct {
        logic               mode;
        logic               visible;
        logic signed [31:0] mnx, mny, mnz, mxx, mxy, mxz;
        logic [LOD_W-1:0]   cur;
        logic [9:0]         quads;
    } chunk_t;

    typedef struct {
        logic [LOD_W-1:0] new_lod;
        logic             mesh;
        logic             gpu;
    } lod_res_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  mode = 1'b0;
    logic                  visible = 1'b0;
    logic signed [31:0]    box_min_x = '0, box_min_y = '0, box_min_z = '0;
    logic signed [31:0]    box_max_x = '0, box_max_y = '0, box_max_z = '0;
    logic [LOD_W-1:0]      current_lod = '0;
    logic [9:0]            chunk_quads = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [LOD_W-1:0]      new_lod;
    logic                  mesh_dirty;
    logic                  gpu_dirty;

    // register copies
    logic [15:0]        r_bias = 16'd256;
    logic [2:0]         r_max_lod = 3'd4;
    logic [31:0]        r_world = 32'd67108864;
    logic [15:0]        r_hmap = 16'd1025;
    logic signed [31:0] r_cam_x = '0, r_cam_y = '0, r_cam_z = '0;

    chunk_t   pending_chunks[$];
    lod_res_t expected_lods[$];
    int       errors = 0;
    int       results_seen = 0;

    distance_lod_selector_core dut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [63:0] axis_dist(logic signed [31:0] cam,
                                              logic signed [31:0] lo,
                                              logic signed [31:0] hi);
        longint t;
        t = 2 * longint'(cam) - longint'(lo) - longint'(hi);
        return (t < 0) ? 64'(-t) : 64'(t);
    endfunction

    function automatic lod_res_t select_lod(chunk_t c);
        lod_res_t   r;
        logic [63:0] ax, ay, az;
        logic [127:0] s, sq_root, cand, lhs, ext, e2, t;
        logic [15:0] bias;
        logic [31:0] hw_div;
        longint     ex, ez, es;
        int         lod, cap, cur, band;
        bit         apply;
        r.new_lod = c.cur;
        r.mesh = 1'b0;
        r.gpu = 1'b0;
        if (c.mnx > c.mxx || (c.mode == MODE_UPDATE && !c.visible))
            return r;
        ax = axis_dist(r_cam_x, c.mnx, c.mxx);
        ay = axis_dist(r_cam_y, c.mny, c.mxy);
        az = axis_dist(r_cam_z, c.mnz, c.mxz);
        s = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay) + 128'(az) * 128'(az);
        sq_root = '0;
        for (int b = 36; b >= 0; b--)
        begin
            cand = sq_root | (128'(1) << b);
            if (cand * cand <= s)
                sq_root = cand;
        end
        bias = (r_bias < BIAS_MIN) ? BIAS_MIN : r_bias;
        lhs = 128'(100) * sq_root * 128'(bias);
        hw_div = (r_hmap > 1) ? 32'(r_hmap) - 1 : 32'd1;
        ex = longint'(c.mxx) - longint'(c.mnx);
        ez = longint'(c.mxz) - longint'(c.mnz);
        es = (ex > ez) ? ex : ez;
        if (es < longint'(ONE_Q16))
            ext = (r_hmap > 1) ? 128'(r_world / 8) : 128'(r_world);
        else
            ext = 128'(es);
        if (ext < 128'(ONE_Q16))
            ext = 128'(ONE_Q16);
        lod = 0;
        for (int i = 0; i < 4; i++)
            if (lhs > 128'(THR[i]) * (ext << 9))
                lod = i + 1;
        cap = (r_max_lod > LOD_TOP) ? int'(LOD_TOP) : int'(r_max_lod);
        if (lod > cap)
            lod = cap;
        cur = int'(c.cur);
        if (lod == cur)
            return r;
        if (c.mode == MODE_SEED)
        begin
            r.new_lod = LOD_W'(lod);
            r.mesh = 1'b1;
            r.gpu = 1'b1;
            return r;
        end
        apply = 1'b1;
        if (lod > cur + 1)
        begin
            e2 = (128'(r_world) * 128'((c.quads == 0) ? 10'd1 : c.quads)) / 128'(hw_div);
            if (e2 < 128'(ONE_Q16))
                e2 = 128'(ONE_Q16);
            band = (lod >= 1) ? lod - 1 : 0;
            if (band > 3)
                band = 3;
            t = 128'(THR[band]);
            e2 = e2 << 9;
            if ((t - 128'(HYST)) * e2 < lhs && lhs < (t + 128'(HYST)) * e2)
                apply = 1'b0;
        end
        else if (lod > cur)
            apply = 1'b0;
        if (apply)
        begin
            r.new_lod = LOD_W'(lod);
            r.mesh = 1'b1;
        end
        return r;
    endfunction

    function automatic chunk_t mk(logic md, logic vis, longint mnx, longint mny,
                                  longint mnz, longint mxx, longint mxy, longint mxz,
                                  int cur, int q);
        chunk_t c;
        c.mode = md;
        c.visible = vis;
        c.mnx = 32'(mnx);
        c.mny = 32'(mny);
        c.mnz = 32'(mnz);
        c.mxx = 32'(mxx);
        c.mxy = 32'(mxy);
        c.mxz = 32'(mxz);
        c.cur = LOD_W'(cur);
        c.quads = 10'(q);
        return c;
    endfunction

    task automatic add_chunk(chunk_t c);
        pending_chunks.insert(pending_chunks.size(), c);
    endtask

    task automatic add_expect(lod_res_t r);
        expected_lods.insert(expected_lods.size(), r);
    endtask

    function automatic chunk_t random_chunk();
        chunk_t c;
        longint e, k, cx, cy, cz;
        int kind;
        kind = $urandom_range(0, 9);
        if (kind == 0)
            return mk(1'($urandom), 1'($urandom), $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom_range(0, 7), $urandom);
        if (kind == 1)
            e = $urandom_range(0, 65535);
        else
            e = longint'($urandom_range(1, 255)) << $urandom_range(8, 20);
        k = $urandom_range(0, 12);
        cx = longint'(r_cam_x) + ((longint'($urandom_range(0, 2000)) - 1000) * k * e) / 1000;
        cy = longint'(r_cam_y) + ((longint'($urandom_range(0, 2000)) - 1000) * k * e) / 1000;
        cz = longint'(r_cam_z) + ((longint'($urandom_range(0, 2000)) - 1000) * k * e) / 1000;
        c = mk(1'($urandom), ($urandom_range(0, 9) != 0), cx - e / 2, cy - e / 4, cz - e / 2,
               cx - e / 2 + e, cy + e / 4, cz - e / 2 + e,
               ($urandom_range(0, 15) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4),
               $urandom_range(0, 1023));
        if (kind == 2)
            c.mxz = c.mnz + 32'($urandom_range(0, 3) * e);
        return c;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_LOD_BIAS:   r_bias = val[15:0];
            CFG_MAX_LOD:    r_max_lod = val[2:0];
            CFG_WORLD_X:    r_world = val;
            CFG_HMAP_WIDTH: r_hmap = val[15:0];
            CFG_CAMERA_X:   r_cam_x = val;
            CFG_CAMERA_Y:   r_cam_y = val;
            CFG_CAMERA_Z:   r_cam_z = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_chunks.size() != 0 || in_valid || expected_lods.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic apply_setting(int p);
        logic [31:0] b, m, w, h, cx, cy, cz;
        b = $urandom_range(64, 1024);
        m = $urandom_range(0, 7);
        w = $urandom;
        h = $urandom_range(0, 4096);
        cx = 32'($urandom_range(0, 1 << 26)) - (1 << 25);
        cy = 32'($urandom_range(0, 1 << 24)) - (1 << 23);
        cz = 32'($urandom_range(0, 1 << 26)) - (1 << 25);
        case (p)
            1: begin b = 0; m = 0; h = 0; end
            2: begin b = 32'hFFFF; m = 7; w = 0; h = 1; end
            3: begin w = 32'hFFFFFFFF; h = 32'hFFFF; cx = 32'h7FFFFFFF; cy = 32'h80000000; end
            4: begin cx = 32'h80000000; cz = 32'h7FFFFFFF; h = 2; end
            5: begin b = 63; m = 4; end
            default: ;
        endcase
        write_reg(CFG_LOD_BIAS, b);
        write_reg(CFG_MAX_LOD, m);
        write_reg(CFG_WORLD_X, w);
        write_reg(CFG_HMAP_WIDTH, h);
        write_reg(CFG_CAMERA_X, cx);
        write_reg(CFG_CAMERA_Y, cy);
        write_reg(CFG_CAMERA_Z, cz);
        write_reg(CFG_UNUSED, $urandom);
    endtask

    // request driver
    chunk_t sent;
    int     burst_left = 0;
    int     gap_left = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                add_expect(select_lod(sent));
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_chunks.size() != 0)
                begin
                    sent = pending_chunks.pop_front();
                    in_valid <= 1'b1;
                    mode <= sent.mode;
                    visible <= sent.visible;
                    box_min_x <= sent.mnx;
                    box_min_y <= sent.mny;
                    box_min_z <= sent.mnz;
                    box_max_x <= sent.mxx;
                    box_max_y <= sent.mxy;
                    box_max_z <= sent.mxz;
                    current_lod <= sent.cur;
                    chunk_quads <= sent.quads;
                    if (burst_left == 0)
                    begin
                        burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 30);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left--;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result receiver: rotating stall pattern plus one long hold
    int  rx_cycle = 0;
    int  hold_left = 0;
    bit  held_once = 0;

    always @(posedge clk)
    begin
        rx_cycle++;
        if (!held_once && results_seen >= 300)
        begin
            held_once = 1;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            case ((rx_cycle / 64) % 4)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 1) == 0);
                2: out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= ($urandom_range(0, 7) != 0);
            endcase
    end

    // result monitor
    always @(posedge clk)
    begin
        lod_res_t e;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_lods.size() == 0)
            begin
                $error("result with no request waiting: new_lod %0d", new_lod);
                errors++;
            end
            else
            begin
                e = expected_lods.pop_front();
                if (new_lod !== e.new_lod)
                begin
                    $error("new_lod expected %0d actual %0d", e.new_lod, new_lod);
                    errors++;
                end
                if (mesh_dirty !== e.mesh)
                begin
                    $error("mesh_dirty expected %0d actual %0d", e.mesh, mesh_dirty);
                    errors++;
                end
                if (gpu_dirty !== e.gpu)
                begin
                    $error("gpu_dirty expected %0d actual %0d", e.gpu, gpu_dirty);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        longint u;
        u = 65536;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed requests under reset registers
        add_chunk(mk(MODE_SEED, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_chunk(mk(MODE_UPDATE, 1, -u, -u, -u, u, u, u, 4, 1));
        add_chunk(mk(MODE_UPDATE, 0, 100 * u, 0, 0, 101 * u, u, u, 0, 5));
        add_chunk(mk(MODE_SEED, 0, 100 * u, 0, 0, 101 * u, u, u, 0, 5));
        add_chunk(mk(MODE_SEED, 1, 5 * u, 0, 0, 4 * u, u, u, 2, 5));
        add_chunk(mk(MODE_UPDATE, 1, 5 * u, 0, 0, 4 * u, u, u, 2, 5));
        add_chunk(mk(MODE_UPDATE, 1, -32'sh80000000, -32'sh80000000,
                     -32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                     32'sh7FFFFFFF, 7, 1023));
        add_chunk(mk(MODE_SEED, 1, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                     32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                     32'sh7FFFFFFF, 0, 0));
        add_chunk(mk(MODE_SEED, 1, -32'sh80000000, -32'sh80000000,
                     -32'sh80000000, -32'sh80000000, -32'sh80000000,
                     -32'sh80000000, 4, 1023));
        add_chunk(mk(MODE_UPDATE, 1, 0, 0, 0, u / 2, 0, u / 2, 0, 0));
        add_chunk(mk(MODE_UPDATE, 1, 20 * u, 0, 0, 21 * u, u, u, 0, 16));
        add_chunk(mk(MODE_UPDATE, 1, 20 * u, 0, 0, 21 * u, u, u, 3, 16));
        add_chunk(mk(MODE_UPDATE, 1, 2 * u, 0, 0, 3 * u, u, u, 0, 16));
        add_chunk(mk(MODE_UPDATE, 1, 2 * u, 0, 0, 3 * u, u, u, 5, 16));
        add_chunk(mk(MODE_UPDATE, 1, 6 * u, 0, 0, 7 * u, u, u, 1, 64));
        add_chunk(mk(MODE_UPDATE, 1, 8 * u, 0, 0, 9 * u, u, u, 1, 1023));
        add_chunk(mk(MODE_SEED, 1, 8 * u, 0, 0, 9 * u, u, u, 7, 0));
        add_chunk(mk(MODE_UPDATE, 1, 0, 0, 0, u, u, 30 * u, 2, 3));
        add_chunk(mk(MODE_SEED, 0, 3 * u, 3 * u, 3 * u, 4 * u, 4 * u, 4 * u,
                     6, 512));
        add_chunk(mk(MODE_UPDATE, 1, u, 0, 0, u, 0, 0, 1, 1));
        wait_idle();

        for (int p = 1; p < PHASES; p++)
        begin
            apply_setting(p);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                add_chunk(random_chunk());
            wait_idle();
        end

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
